@@ rtl/hmt_pkg.sv @@
package hmt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int ID_BITS     = 8;

	localparam int IDX_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
	localparam int OP_W       = 3;
	localparam int ST_W       = 3;
	localparam int IN_ID_W    = 8;
	localparam int RES_ID_W   = 8;
	localparam int HB_W       = 32;
	localparam int TIME_W     = 32;
	localparam int MCOUNT_W   = 5;
	localparam int SELF_ID_W  = 8;
	localparam int TIMEOUT_W  = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	localparam logic [OP_W-1:0] OP_JOIN  = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
	localparam logic [OP_W-1:0] OP_MERGE = 3'd2;
	localparam logic [OP_W-1:0] OP_BUMP  = 3'd3;
	localparam logic [OP_W-1:0] OP_SWEEP = 3'd4;

	localparam logic [ST_W-1:0] ST_ADDED        = 3'd0;
	localparam logic [ST_W-1:0] ST_UPDATED      = 3'd1;
	localparam logic [ST_W-1:0] ST_NOT_NEWER    = 3'd2;
	localparam logic [ST_W-1:0] ST_UNKNOWN      = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL         = 3'd4;
	localparam logic [ST_W-1:0] ST_REMOVED      = 3'd5;
	localparam logic [ST_W-1:0] ST_NONE_REMOVED = 3'd6;
	localparam logic [ST_W-1:0] ST_BUMPED       = 3'd7;

	localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAIL_TIMEOUT = 1'b1;

	localparam logic [SELF_ID_W-1:0] SELF_ID_RST      = 8'd1;
	localparam logic [TIMEOUT_W-1:0] FAIL_TIMEOUT_RST = 16'd15;

	typedef logic [ID_BITS-1:0] id_t;

	typedef struct packed {
		id_t               id;
		logic [HB_W-1:0]   hb;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		id_t               id;
		logic [HB_W-1:0]   hb;
		logic [TIME_W-1:0] stamp;
	} item_t;

endpackage

@@ rtl/hmt_ifs.sv @@
interface hmt_in_if;
	import hmt_pkg::*;
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     opcode;
	logic [IN_ID_W-1:0]  member_id;
	logic [HB_W-1:0]     member_heartbeat;
	logic [TIME_W-1:0]   current_time;

	modport source (output valid, opcode, member_id, member_heartbeat, current_time,
		input ready);
	modport sink (input valid, opcode, member_id, member_heartbeat, current_time,
		output ready);
endinterface

interface hmt_out_if;
	import hmt_pkg::*;
	logic                valid;
	logic                ready;
	logic [ST_W-1:0]     status;
	logic [RES_ID_W-1:0] result_id;
	logic [HB_W-1:0]     result_heartbeat;
	logic [MCOUNT_W-1:0] member_count;
	logic                last;

	modport source (output valid, status, result_id, result_heartbeat, member_count, last,
		input ready);
	modport sink (input valid, status, result_id, result_heartbeat, member_count, last,
		output ready);
endinterface

@@ rtl/hmt_front.sv @@
module hmt_front (
	hmt_in_if.sink          req,
	input  logic            q_not_full,
	output logic            push,
	output hmt_pkg::item_t  push_item
);
	import hmt_pkg::*;

	logic op_known;

	always_comb begin
		unique case (req.opcode) inside
			OP_JOIN, OP_ADD, OP_MERGE, OP_BUMP, OP_SWEEP: op_known = 1'b1;
			default: op_known = 1'b0;
		endcase
	end

	assign req.ready = q_not_full;

	// unused opcodes are taken and dropped here
	assign push = req.valid && q_not_full && op_known;

	assign push_item = '{op: req.opcode, id: ID_BITS'(req.member_id),
		hb: req.member_heartbeat, stamp: req.current_time};

endmodule

@@ rtl/hmt_queue.sv @@
module hmt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hmt_pkg::item_t  push_item,
	output logic            not_full,
	output logic            pop_valid,
	input  logic            pop_ready,
	output hmt_pkg::item_t  head
);
	import hmt_pkg::*;

	item_t             slot_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign not_full  = cnt_q != QCNT_W'(Q_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign head      = slot_q[rd_ptr_q];
	assign do_push   = push && not_full;
	assign do_pop    = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(Q_DEPTH))
		else $error("queue occupancy above depth");

	a_pop_moves_head: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (cnt_q == $past(cnt_q) - QCNT_W'(1)))
		else $error("queue count did not drop on pop");

	a_push_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + QCNT_W'(1)))
		else $error("queue count did not rise on push");

endmodule

@@ rtl/hmt_back.sv @@
module hmt_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	output logic                             q_ready,
	input  hmt_pkg::item_t                   q_item,
	input  logic [hmt_pkg::SELF_ID_W-1:0]    self_id,
	input  logic [hmt_pkg::TIMEOUT_W-1:0]    fail_timeout,
	hmt_out_if.source                        rsp
);
	import hmt_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_APPEND = 3'd1;
	localparam logic [2:0] S_COUNT  = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;
	localparam logic [2:0] S_FLUSH  = 3'd5;

	// entry memory: one write and one registered read a cycle
	entry_t            mem [TABLE_DEPTH];
	entry_t            rdata_q;

	logic [2:0]        state_q;
	logic [OP_W-1:0]   op_q;
	id_t               id_q;
	logic [HB_W-1:0]   hb_q;
	logic [TIME_W-1:0] now_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  res_cnt_q;
	logic [CNT_W-1:0]  surv_q;
	logic [HB_W-1:0]   own_hb_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  wr_q;
	logic              any_q;
	logic              join_self_q;

	logic              pend_valid_q;
	logic [ST_W-1:0]   pend_status_q;
	id_t               pend_id_q;
	logic [HB_W-1:0]   pend_hb_q;

	logic                out_valid_q;
	logic [ST_W-1:0]     out_status_q;
	logic [RES_ID_W-1:0] out_id_q;
	logic [HB_W-1:0]     out_hb_q;
	logic [MCOUNT_W-1:0] out_count_q;
	logic                out_last_q;

	id_t               sid;
	logic              last_idx;
	logic              survive;
	logic              table_full;
	logic [IDX_W-1:0]  count_idx;
	logic              emit_want;
	logic [ST_W-1:0]   emit_status;
	id_t               emit_id;
	logic [HB_W-1:0]   emit_hb;
	logic              out_space;
	logic              can_emit;
	logic              go;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_data;
	logic [IDX_W-1:0]  idx_next;
	logic              out_load;
	logic              flush_go;
	logic              pop;

	assign sid        = ID_BITS'(self_id);
	assign last_idx   = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
	assign survive    = (now_q - rdata_q.stamp) < TIME_W'(fail_timeout);
	assign table_full = count_q == CNT_W'(TABLE_DEPTH);
	assign count_idx  = IDX_W'(count_q);
	assign out_space  = !out_valid_q || rsp.ready;
	assign can_emit   = !pend_valid_q || out_space;
	assign q_ready    = state_q == S_IDLE;
	assign pop        = q_valid && q_ready;
	assign flush_go   = (state_q == S_FLUSH) && out_space;

	always_comb begin
		emit_want   = 1'b0;
		emit_status = ST_ADDED;
		emit_id     = '0;
		emit_hb     = '0;
		wr_en       = 1'b0;
		wr_addr     = idx_q;
		wr_data     = rdata_q;
		unique case (state_q)
			S_APPEND: begin
				emit_want = 1'b1;
				wr_addr   = count_idx;
				if (join_self_q) begin
					emit_id = sid;
					emit_hb = own_hb_q + HB_W'(1);
					wr_en   = 1'b1;
					wr_data = '{id: sid, hb: own_hb_q + HB_W'(1), stamp: now_q};
				end else if (!table_full) begin
					emit_id = id_q;
					emit_hb = hb_q;
					wr_en   = 1'b1;
					wr_data = '{id: id_q, hb: hb_q, stamp: now_q};
				end else begin
					emit_status = ST_FULL;
					emit_id     = id_q;
				end
			end
			S_SCAN: begin
				case (op_q)
					OP_MERGE: begin
						if (rdata_q.id == id_q) begin
							emit_want = 1'b1;
							emit_id   = id_q;
							if (hb_q > rdata_q.hb) begin
								emit_status = ST_UPDATED;
								emit_hb     = hb_q;
								wr_en       = 1'b1;
								wr_data     = '{id: id_q, hb: hb_q, stamp: now_q};
							end else begin
								emit_status = ST_NOT_NEWER;
								emit_hb     = rdata_q.hb;
							end
						end
					end
					OP_BUMP: begin
						if (rdata_q.id == sid) begin
							emit_want   = 1'b1;
							emit_status = ST_BUMPED;
							emit_id     = sid;
							emit_hb     = rdata_q.hb + HB_W'(1);
							wr_en       = 1'b1;
							wr_data     = '{id: sid, hb: rdata_q.hb + HB_W'(1), stamp: now_q};
						end
					end
					default: begin
						// sweep: report expired entries, pack survivors downward
						if (!survive) begin
							emit_want   = 1'b1;
							emit_status = ST_REMOVED;
							emit_id     = rdata_q.id;
							emit_hb     = rdata_q.hb;
						end else begin
							wr_en   = 1'b1;
							wr_addr = wr_q;
						end
					end
				endcase
			end
			S_DONE: begin
				emit_want = !any_q;
				if (op_q == OP_MERGE) begin
					emit_status = ST_UNKNOWN;
					emit_id     = id_q;
				end else if (op_q == OP_BUMP) begin
					emit_status = ST_UNKNOWN;
					emit_id     = sid;
				end else begin
					emit_status = ST_NONE_REMOVED;
				end
			end
			default: ;
		endcase
	end

	assign go       = !emit_want || can_emit;
	assign out_load = (emit_want && go && pend_valid_q) || flush_go;

	always_comb begin
		idx_next = idx_q;
		unique case (state_q)
			S_IDLE:  idx_next = '0;
			S_COUNT: idx_next = last_idx ? '0 : idx_q + IDX_W'(1);
			S_SCAN: begin
				if (go) begin
					idx_next = last_idx ? '0 : idx_q + IDX_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en && go) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[idx_next];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			res_cnt_q    <= '0;
			surv_q       <= '0;
			own_hb_q     <= '0;
			idx_q        <= '0;
			wr_q         <= '0;
			any_q        <= 1'b0;
			join_self_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			idx_q <= idx_next;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit_want && go) begin
				pend_valid_q <= 1'b1;
			end else if (flush_go) begin
				pend_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						any_q  <= 1'b0;
						surv_q <= '0;
						case (q_item.op)
							OP_JOIN, OP_ADD: begin
								state_q     <= S_APPEND;
								join_self_q <= (q_item.op == OP_JOIN) && (count_q == '0);
								if ((q_item.op == OP_JOIN) && (count_q == '0)) begin
									res_cnt_q <= CNT_W'(2);
								end else if (!table_full) begin
									res_cnt_q <= count_q + CNT_W'(1);
								end else begin
									res_cnt_q <= count_q;
								end
							end
							OP_MERGE, OP_BUMP: begin
								res_cnt_q <= count_q;
								state_q   <= (count_q == '0) ? S_DONE : S_SCAN;
							end
							default: begin
								res_cnt_q <= '0;
								state_q   <= (count_q == '0) ? S_DONE : S_COUNT;
							end
						endcase
					end
				end
				S_APPEND: begin
					if (go) begin
						if (join_self_q) begin
							own_hb_q    <= own_hb_q + HB_W'(1);
							count_q     <= count_q + CNT_W'(1);
							join_self_q <= 1'b0;
						end else begin
							if (!table_full) begin
								count_q <= count_q + CNT_W'(1);
							end
							state_q <= S_FLUSH;
						end
					end
				end
				S_COUNT: begin
					surv_q <= surv_q + CNT_W'(survive);
					if (last_idx) begin
						res_cnt_q <= surv_q + CNT_W'(survive);
						wr_q      <= '0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (go) begin
						case (op_q)
							OP_MERGE: begin
								if (emit_want) begin
									any_q   <= 1'b1;
									state_q <= S_DONE;
								end else if (last_idx) begin
									state_q <= S_DONE;
								end
							end
							OP_BUMP: begin
								if (emit_want) begin
									any_q <= 1'b1;
								end
								if (last_idx) begin
									state_q <= S_DONE;
								end
							end
							default: begin
								if (!survive) begin
									any_q <= 1'b1;
								end else begin
									wr_q <= wr_q + IDX_W'(1);
								end
								if (last_idx) begin
									count_q <= res_cnt_q;
									state_q <= S_DONE;
								end
							end
						endcase
					end
				end
				S_DONE: begin
					if (go) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (out_space) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q  <= q_item.op;
			id_q  <= q_item.id;
			hb_q  <= q_item.hb;
			now_q <= q_item.stamp;
		end
		if (emit_want && go) begin
			pend_status_q <= emit_status;
			pend_id_q     <= emit_id;
			pend_hb_q     <= emit_hb;
		end
		if (out_load) begin
			out_status_q <= pend_status_q;
			out_id_q     <= RES_ID_W'(pend_id_q);
			out_hb_q     <= pend_hb_q;
			out_count_q  <= MCOUNT_W'(res_cnt_q);
			out_last_q   <= flush_go;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.status           = out_status_q;
	assign rsp.result_id        = out_id_q;
	assign rsp.result_heartbeat = out_hb_q;
	assign rsp.member_count     = out_count_q;
	assign rsp.last             = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("member count above table depth");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_valid_q)
		else $error("pending result left over between items");

	a_flush_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH) |-> pend_valid_q)
		else $error("item ended with no result");

	a_pack_behind_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && op_q == OP_SWEEP) |-> (wr_q <= idx_q))
		else $error("sweep write index passed read index");

endmodule

@@ rtl/heartbeat_membership_table_top.sv @@
// Accepted words wait in the two-deep queue until the back is idle. Join and add append
// (join on an empty table adds self first), merge and self bump scan the N valid entries
// (at most 16), sweep counts, then scans them; results leave via the output register.
// Throughput: one item at a time in the back, one entry a cycle through the single memory
// read port unless the output stalls a scan; the front keeps accepting until the queue fills.
// Reset: table empty, own heartbeat zero, self_id 1, fail_timeout 15; no clearing pass.
module heartbeat_membership_table_top (
	input  logic                               clk,
	input  logic                               arst_n,
	hmt_in_if.sink                             req,
	hmt_out_if.source                          rsp,
	input  logic                               cfg_we,
	input  logic [hmt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hmt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import hmt_pkg::*;

	logic [SELF_ID_W-1:0] self_id_q;
	logic [TIMEOUT_W-1:0] fail_timeout_q;
	logic                 push;
	item_t                push_item;
	logic                 q_not_full;
	logic                 q_valid;
	logic                 q_ready;
	item_t                q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_id_q      <= SELF_ID_RST;
			fail_timeout_q <= FAIL_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SELF_ID:      self_id_q      <= cfg_wdata[SELF_ID_W-1:0];
				CFG_FAIL_TIMEOUT: fail_timeout_q <= cfg_wdata[TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	hmt_front u_front (
		.req        (req),
		.q_not_full (q_not_full),
		.push       (push),
		.push_item  (push_item)
	);

	hmt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.not_full  (q_not_full),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.head      (q_head)
	);

	hmt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_item       (q_head),
		.self_id      (self_id_q),
		.fail_timeout (fail_timeout_q),
		.rsp          (rsp)
	);

endmodule
